### rtl/core/boxsup_pkg.sv
// shared types, constants and helpers for the box overlap suppression block
package boxsup_pkg;

  localparam int unsigned MaxBoxes  = 64;
  localparam int unsigned IdxW      = $clog2(MaxBoxes);
  localparam int unsigned CntW      = IdxW + 1;
  localparam int unsigned FracBits  = 4;
  localparam int unsigned SideW     = 18;
  localparam int unsigned AreaW     = 34;
  localparam int unsigned ThrW      = 17;
  localparam int unsigned ProdW     = AreaW + ThrW + 1;
  localparam logic [ThrW-1:0] ThrReset = ThrW'(32768);
  localparam logic [1:0] RegThreshold = 2'd0;

  typedef struct packed {
    logic [15:0] box_left;
    logic [15:0] box_top;
    logic [15:0] box_right;
    logic [15:0] box_bottom;
    logic [15:0] box_score;
    logic        list_end;
  } box_in_t;

  typedef struct packed {
    logic [15:0] kept_left;
    logic [15:0] kept_top;
    logic [15:0] kept_right;
    logic [15:0] kept_bottom;
    logic [15:0] kept_score;
    logic        final_result;
    logic        list_overflowed;
  } box_out_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
  } coord_t;

  // request to and answer from the shared overlap unit
  typedef struct packed {
    logic              start;
    coord_t            box_a;
    coord_t            box_b;
    logic [AreaW-1:0]  area_a;
    logic [AreaW-1:0]  area_b;
  } ovl_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } ovl_rsp_t;

  // side length with the inclusive one-pixel term, clamped at zero
  function automatic logic [SideW-1:0] side_len(logic [15:0] lo, logic [15:0] hi);
    logic signed [SideW:0] s;
    s = $signed({3'b000, hi}) - $signed({3'b000, lo}) + (SideW+1)'(1 << FracBits);
    side_len = s[SideW] ? '0 : s[SideW-1:0];
  endfunction

endpackage

### rtl/core/boxsup_overlap.sv
// multi-cycle overlap test: intersection and union, then cross-multiplied compare
module boxsup_overlap (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [boxsup_pkg::ThrW-1:0]  threshold_i,
  input  boxsup_pkg::ovl_req_t         req_i,
  output boxsup_pkg::ovl_rsp_t         rsp_o
);

  localparam int unsigned AreaW = boxsup_pkg::AreaW;
  localparam int unsigned ProdW = boxsup_pkg::ProdW;
  localparam int unsigned SideW = boxsup_pkg::SideW;

  logic [3:0]       stage_q, stage_d;
  logic [SideW-1:0] sx_q, sy_q;
  logic [AreaW-1:0] inter_q, uni_q;
  logic [ProdW-1:0] lhs_q, rhs_q;
  logic [15:0]      x1, y1, x2, y2;

  always_comb begin
    x1 = (req_i.box_a.left  > req_i.box_b.left)  ? req_i.box_a.left  : req_i.box_b.left;
    y1 = (req_i.box_a.top   > req_i.box_b.top)   ? req_i.box_a.top   : req_i.box_b.top;
    x2 = (req_i.box_a.right < req_i.box_b.right) ? req_i.box_a.right : req_i.box_b.right;
    y2 = (req_i.box_a.bottom < req_i.box_b.bottom) ? req_i.box_a.bottom
                                                   : req_i.box_b.bottom;
  end

  always_comb begin
    stage_d = {stage_q[2:0], req_i.start};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  // stage 0 sides, 1 intersection, 2 union, 3 both products
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sx_q <= boxsup_pkg::side_len(x1, x2);
      sy_q <= boxsup_pkg::side_len(y1, y2);
    end
    if (stage_q[0]) inter_q <= AreaW'(sx_q) * AreaW'(sy_q);
    if (stage_q[1]) uni_q <= req_i.area_a + req_i.area_b - inter_q;
    if (stage_q[2]) begin
      lhs_q <= ProdW'({inter_q, 16'h0});
      rhs_q <= ProdW'(uni_q) * ProdW'(threshold_i);
    end
  end

  assign rsp_o.done = stage_q[3];
  assign rsp_o.hit  = (uni_q != '0) && (lhs_q >= rhs_q);

endmodule

### rtl/core/box_overlap_suppression.sv
// top level of the box overlap suppression block: sorted store, sequencer, apb register
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | box_in_t (edges, score, list end)
//  out     | output    | out_valid/out_ready | box_out_t (edges, score, last, overflow)
//  apb     | input     | psel/penable/pready | overlap_threshold at address 0
//
// a box is inserted by moving each lower-score box up one place, a write and a read each
// on the last box the suppression pass tests each live pair, one after another, in the shared
// overlap unit, then reads out each survivor as a beat and skips each removed box
// each emitted beat waits in the output register until taken
// reset clears counts, flags and the threshold to one half; stores need no clearing
module box_overlap_suppression (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  boxsup_pkg::box_in_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output boxsup_pkg::box_out_t  out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned IdxW  = boxsup_pkg::IdxW;
  localparam int unsigned CntW  = boxsup_pkg::CntW;
  localparam int unsigned AreaW = boxsup_pkg::AreaW;
  localparam int unsigned N     = boxsup_pkg::MaxBoxes;

  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StShift  = 8'b0000_0010,
    StOuterI = 8'b0000_0100,
    StReadJ  = 8'b0000_1000,
    StTest   = 8'b0001_0000,
    StEmitRd = 8'b0010_0000,
    StEmit   = 8'b0100_0000,
    StLoad   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // box stores: one write port, registered reads
  boxsup_pkg::coord_t coord_mem [N];
  logic [15:0]        score_mem [N];
  logic [AreaW-1:0]   area_mem  [N];

  logic [N-1:0]           supp_q, supp_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   ovf_q, ovf_d;
  logic                   end_q, end_d;
  logic [CntW-1:0]        pos_q, pos_d;
  logic [IdxW-1:0]        i_q, i_d;
  logic [CntW-1:0]        j_q, j_d;
  logic [boxsup_pkg::ThrW-1:0] thr_q;

  boxsup_pkg::box_in_t    new_q;
  logic [AreaW-1:0]       new_area_q;

  // write port
  logic                   we;
  logic [IdxW-1:0]        waddr;
  boxsup_pkg::coord_t     wcoord;
  logic [15:0]            wscore;
  logic [AreaW-1:0]       warea;

  // read port
  logic [IdxW-1:0]        raddr;
  boxsup_pkg::coord_t     rcoord_q;
  logic [15:0]            rscore_q;
  logic [AreaW-1:0]       rarea_q;

  // held copy of the outer box during its inner sweep
  boxsup_pkg::coord_t     a_coord_q;
  logic [15:0]            a_score_q;
  logic [AreaW-1:0]       a_area_q;
  logic                   load_a_q, load_a_d;

  boxsup_pkg::ovl_req_t   ovl_req;
  boxsup_pkg::ovl_rsp_t   ovl_rsp;
  logic                   test_busy_q, test_busy_d;

  boxsup_pkg::box_out_t   out_q, out_d;
  logic                   out_valid_q, out_valid_d;
  logic                   in_fire, out_fire;
  logic [CntW-1:0]        last_idx;
  logic                   any_left;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_q && out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // apb register
  assign pready = 1'b1;
  assign prdata = (paddr == boxsup_pkg::RegThreshold) ? 32'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= boxsup_pkg::ThrReset;
    end else if (psel && penable && pwrite && paddr == boxsup_pkg::RegThreshold) begin
      thr_q <= pwdata[boxsup_pkg::ThrW-1:0];
    end
  end

  // highest surviving index, for the last-beat mark
  always_comb begin
    last_idx = '0;
    any_left = 1'b0;
    for (int k = 0; k < N; k++) begin
      if (!supp_q[k] && CntW'(k) < count_q) begin
        last_idx = CntW'(k);
        any_left = 1'b1;
      end
    end
  end

  assign ovl_req.start  = (state_q == StTest) && !test_busy_q;
  assign ovl_req.box_a  = a_coord_q;
  assign ovl_req.box_b  = rcoord_q;
  assign ovl_req.area_a = a_area_q;
  assign ovl_req.area_b = rarea_q;

  boxsup_overlap u_overlap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .threshold_i (thr_q),
    .req_i       (ovl_req),
    .rsp_o       (ovl_rsp)
  );

  always_comb begin
    state_d     = state_q;
    supp_d      = supp_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    end_d       = end_q;
    pos_d       = pos_q;
    i_d         = i_q;
    j_d         = j_q;
    load_a_d    = 1'b0;
    test_busy_d = test_busy_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    we          = 1'b0;
    waddr       = pos_q[IdxW-1:0];
    wcoord      = rcoord_q;
    wscore      = rscore_q;
    warea       = rarea_q;
    raddr       = '0;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          end_d = in_data_i.list_end;
          if (count_q == CntW'(N)) begin
            ovf_d   = 1'b1;
            state_d = in_data_i.list_end ? StOuterI : StIdle;
            i_d     = '0;
          end else begin
            pos_d   = count_q;
            raddr   = IdxW'(count_q - 1'b1);
            state_d = StShift;
          end
        end
      end
      // walk down from the tail, moving lower scores up one place
      StShift: begin
        if (pos_q != '0 && rscore_q < new_q.box_score) begin
          we      = 1'b1;
          pos_d   = pos_q - 1'b1;
          raddr   = IdxW'(pos_q - 2'd2);
          state_d = StLoad;
        end else begin
          we      = 1'b1;
          wcoord  = '{new_q.box_left, new_q.box_top, new_q.box_right, new_q.box_bottom};
          wscore  = new_q.box_score;
          warea   = new_area_q;
          count_d = count_q + 1'b1;
          i_d     = '0;
          state_d = end_q ? StOuterI : StIdle;
        end
      end
      // wait state for the registered read to land
      StLoad: begin
        raddr   = IdxW'(pos_q - 1'b1);
        state_d = StShift;
      end
      StOuterI: begin
        raddr = i_q;
        if (CntW'(i_q) + 1'b1 >= count_q) begin
          i_d     = '0;
          state_d = StEmitRd;
        end else if (supp_q[i_q]) begin
          i_d = i_q + 1'b1;
        end else begin
          load_a_d = 1'b1;
          j_d      = CntW'(i_q) + 1'b1;
          state_d  = StReadJ;
        end
      end
      StReadJ: begin
        raddr = j_q[IdxW-1:0];
        if (j_q >= count_q) begin
          i_d     = i_q + 1'b1;
          state_d = StOuterI;
        end else if (supp_q[j_q[IdxW-1:0]]) begin
          j_d = j_q + 1'b1;
        end else begin
          test_busy_d = 1'b0;
          state_d     = StTest;
        end
      end
      StTest: begin
        raddr = j_q[IdxW-1:0];
        if (!test_busy_q) test_busy_d = 1'b1;
        if (ovl_rsp.done) begin
          if (ovl_rsp.hit) supp_d[j_q[IdxW-1:0]] = 1'b1;
          test_busy_d = 1'b0;
          j_d         = j_q + 1'b1;
          state_d     = StReadJ;
        end
      end
      StEmitRd: begin
        raddr = i_q;
        if (!any_left || CntW'(i_q) >= count_q) begin
          supp_d  = '0;
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = StIdle;
        end else if (supp_q[i_q]) begin
          i_d = i_q + 1'b1;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        raddr = i_q;
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d = '{rcoord_q.left, rcoord_q.top, rcoord_q.right, rcoord_q.bottom,
                    rscore_q, CntW'(i_q) == last_idx, ovf_q};
          if (CntW'(i_q) == last_idx) begin
            supp_d  = '0;
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = StIdle;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = StEmitRd;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      supp_q      <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      end_q       <= 1'b0;
      pos_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      load_a_q    <= 1'b0;
      test_busy_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      supp_q      <= supp_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      end_q       <= end_d;
      pos_q       <= pos_d;
      i_q         <= i_d;
      j_q         <= j_d;
      load_a_q    <= load_a_d;
      test_busy_q <= test_busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers and store ports
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_fire) begin
      new_q      <= in_data_i;
      new_area_q <=
        AreaW'(boxsup_pkg::side_len(in_data_i.box_left, in_data_i.box_right)) *
        AreaW'(boxsup_pkg::side_len(in_data_i.box_top, in_data_i.box_bottom));
    end
    if (we) begin
      coord_mem[waddr] <= wcoord;
      score_mem[waddr] <= wscore;
      area_mem[waddr]  <= warea;
    end
    rcoord_q <= coord_mem[raddr];
    rscore_q <= score_mem[raddr];
    rarea_q  <= area_mem[raddr];
    if (load_a_q) begin
      a_coord_q <= rcoord_q;
      a_score_q <= rscore_q;
      a_area_q  <= rarea_q;
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(N))
    else $error("box count beyond capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != StIdle || count_q == CntW'(N) || $past(count_q) == CntW'(N)))
    else $error("accepted box not processed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovl_rsp.done |-> state_q == StTest)
    else $error("overlap result outside a test");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StTest) |-> a_score_q >= rscore_q)
    else $error("store out of score order");
`endif

endmodule

### dv/box_overlap_suppression_tb.sv
// testbench for the box overlap suppression block: directed and random box lists checked against a predictor
`timescale 1ns / 100ps

class nms_scoreboard;
  // boxes of the list being loaded, kept in descending score order
  boxsup_pkg::box_in_t    list_q[$];
  bit                     overflow;
  logic [16:0]            threshold;
  boxsup_pkg::box_out_t   survivors_q[$];
  int                     errors;

  function new();
    threshold = boxsup_pkg::ThrReset;
    errors = 0;
    overflow = 0;
  endfunction

  // side with the inclusive one-pixel term, never negative
  function automatic longint side(longint lo, longint hi);
    longint s;
    s = hi - lo + 16;
    return (s > 0) ? s : 0;
  endfunction

  function automatic longint area_of(boxsup_pkg::box_in_t b);
    return side(b.box_left, b.box_right) * side(b.box_top, b.box_bottom);
  endfunction

  function automatic bit overlapping(boxsup_pkg::box_in_t a, boxsup_pkg::box_in_t b);
    longint inter, uni, x1, y1, x2, y2;
    x1 = (a.box_left > b.box_left) ? a.box_left : b.box_left;
    y1 = (a.box_top > b.box_top) ? a.box_top : b.box_top;
    x2 = (a.box_right < b.box_right) ? a.box_right : b.box_right;
    y2 = (a.box_bottom < b.box_bottom) ? a.box_bottom : b.box_bottom;
    inter = side(x1, x2) * side(y1, y2);
    uni = area_of(a) + area_of(b) - inter;
    if (uni == 0) return 0;
    return inter * 65536 >= longint'(threshold) * uni;
  endfunction

  // note one accepted input beat
  function void note_box(boxsup_pkg::box_in_t b);
    int pos;
    bit gone[boxsup_pkg::MaxBoxes];
    int last;
    boxsup_pkg::box_out_t r;
    if (list_q.size() >= boxsup_pkg::MaxBoxes) overflow = 1;
    else begin
      pos = list_q.size();
      while (pos > 0 && list_q[pos-1].box_score < b.box_score) pos--;
      list_q.insert(pos, b);
    end
    if (!b.list_end) return;
    foreach (gone[i]) gone[i] = 0;
    foreach (list_q[i]) begin
      if (!gone[i])
        for (int j = i + 1; j < list_q.size(); j++)
          if (!gone[j] && overlapping(list_q[i], list_q[j])) gone[j] = 1;
    end
    last = -1;
    foreach (list_q[i]) if (!gone[i]) last = i;
    foreach (list_q[i]) begin
      if (!gone[i]) begin
        r.kept_left = list_q[i].box_left;
        r.kept_top = list_q[i].box_top;
        r.kept_right = list_q[i].box_right;
        r.kept_bottom = list_q[i].box_bottom;
        r.kept_score = list_q[i].box_score;
        r.final_result = (i == last);
        r.list_overflowed = overflow;
        survivors_q.insert(survivors_q.size(), r);
      end
    end
    list_q.delete();
    overflow = 0;
  endfunction

  function void report(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endfunction

  // check one accepted output beat against the oldest survivor
  function void check_beat(boxsup_pkg::box_out_t got);
    boxsup_pkg::box_out_t want;
    if (survivors_q.size() == 0) begin
      report("unexpected beat", longint'(got.kept_score), 0);
      return;
    end
    want = survivors_q.pop_front();
    if (got.kept_left != want.kept_left) report("kept_left", got.kept_left, want.kept_left);
    if (got.kept_top != want.kept_top) report("kept_top", got.kept_top, want.kept_top);
    if (got.kept_right != want.kept_right)
      report("kept_right", got.kept_right, want.kept_right);
    if (got.kept_bottom != want.kept_bottom)
      report("kept_bottom", got.kept_bottom, want.kept_bottom);
    if (got.kept_score != want.kept_score)
      report("kept_score", got.kept_score, want.kept_score);
    if (got.final_result != want.final_result)
      report("final_result", got.final_result, want.final_result);
    if (got.list_overflowed != want.list_overflowed)
      report("list_overflowed", got.list_overflowed, want.list_overflowed);
  endfunction
endclass

module box_overlap_suppression_tb;

  // generous bound on the length of the whole run, worst lists of pair tests included
  localparam longint CycleLimit = 3_000_000;

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  in_valid_i = 0;
  logic                  in_ready_o;
  boxsup_pkg::box_in_t   in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 0;
  boxsup_pkg::box_out_t  out_data_o;
  logic                  psel = 0;
  logic                  penable = 0;
  logic                  pwrite = 0;
  logic [1:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  nms_scoreboard board = new();
  longint cycle_count = 0;
  // when set, both sides run without idle cycles
  bit busy_stretch = 0;
  int box_total = 0;

  box_overlap_suppression u_top (.*);

  always #5 clk_i = ~clk_i;

  // receiver: random stalls, check every taken beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_beat(out_data_o);
    out_ready_i <= busy_stretch ? 1'b1 : ($urandom_range(99) >= 34);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("box_overlap_suppression_tb failed");
      $finish;
    end
  end

  // setup and access cycle on the register port
  task automatic write_threshold(logic [16:0] value);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= boxsup_pkg::RegThreshold;
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.threshold = value;
  endtask

  // one beat on the input channel, with random idle cycles ahead of it
  // valid stays up after the beat until the next idle cycle, the next beat or a drain replaces it
  task automatic send_box(boxsup_pkg::box_in_t b);
    while (!busy_stretch && $urandom_range(99) < 34) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_box(b);
    box_total++;
  endtask

  // random box near a cluster center so overlaps are common
  function automatic boxsup_pkg::box_in_t clustered_box(int cx, int cy, bit last);
    boxsup_pkg::box_in_t b;
    int w, h;
    w = $urandom_range(400, 1);
    h = $urandom_range(400, 1);
    b.box_left = 16'(cx + $urandom_range(80));
    b.box_top = 16'(cy + $urandom_range(80));
    b.box_right = 16'(b.box_left + w);
    b.box_bottom = 16'(b.box_top + h);
    b.box_score = ($urandom_range(3) == 0) ? 16'($urandom_range(3) * 16384)
                                           : 16'($urandom);
    b.list_end = last;
    return b;
  endfunction

  function automatic boxsup_pkg::box_in_t wild_box(bit last);
    boxsup_pkg::box_in_t b;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    b = raw[$bits(boxsup_pkg::box_in_t)-1:0];
    b.list_end = last;
    return b;
  endfunction

  task automatic wait_drained();
    in_valid_i <= 0;
    while (board.survivors_q.size() != 0) @(posedge clk_i);
    // the block may still be finishing a list with no survivors
    repeat (50) @(posedge clk_i);
  endtask

  task automatic send_list(int n, bit wild);
    int cx, cy;
    cx = $urandom_range(60000);
    cy = $urandom_range(60000);
    for (int i = 0; i < n; i++)
      send_box(wild ? wild_box(i == n - 1) : clustered_box(cx, cy, i == n - 1));
  endtask

  initial begin
    boxsup_pkg::box_in_t b;
    int n;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: identical boxes, tie scores, extremes, inverted and degenerate boxes
    b = '{16'd100, 16'd100, 16'd200, 16'd200, 16'd5000, 1'b0};
    send_box(b);
    send_box(b);                       // tie, full overlap, removed
    b.box_score = 16'hFFFF; b.box_left = 16'd150; send_box(b);
    send_box('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0});
    send_box('{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h8000, 1'b0});
    send_box('{16'd500, 16'd500, 16'd10, 16'd10, 16'd7, 1'b0});    // inverted
    send_box('{16'd600, 16'd600, 16'd580, 16'd580, 16'd7, 1'b1});  // inverted, ends
    // single box list
    send_box('{16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0001, 1'b1});
    // two zero-area boxes never suppress each other
    send_box('{16'd300, 16'd300, 16'd0, 16'd0, 16'd9, 1'b0});
    send_box('{16'd300, 16'd300, 16'd0, 16'd0, 16'd9, 1'b1});
    wait_drained();

    // threshold zero: any pair with a nonzero union is a hit, overlapping or not
    write_threshold(17'd0);
    send_list(6, 0);
    wait_drained();
    // threshold 1.0 exactly removes the identical copy, and above it nothing is removed
    write_threshold(17'd65536);
    b = '{16'd10, 16'd10, 16'd50, 16'd50, 16'd3, 1'b0};
    send_box(b);
    b.list_end = 1;
    send_box(b);
    wait_drained();
    write_threshold(17'h1FFFF);
    send_list(5, 0);
    wait_drained();

    // overflow: capacity plus a few, the marked box itself dropped
    write_threshold(17'd40000);
    for (int i = 0; i < boxsup_pkg::MaxBoxes + 3; i++)
      send_box(wild_box(i == boxsup_pkg::MaxBoxes + 2));
    wait_drained();

    // pause until every survivor is out, then a stretch with no idling
    busy_stretch = 1;
    send_list(8, 0);
    send_list(5, 1);
    wait_drained();
    busy_stretch = 0;

    // random lists, mostly clustered, threshold changed between phases
    while (box_total < 160) begin
      if ($urandom_range(3) == 0) begin
        wait_drained();
        write_threshold(($urandom_range(5) == 0) ? 17'($urandom) : 17'($urandom_range(65536)));
      end
      n = ($urandom_range(9) == 0) ? $urandom_range(24, 10) : $urandom_range(6, 1);
      send_list(n, $urandom_range(4) == 0);
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (board.errors == 0 && board.survivors_q.size() == 0)
      $display("box_overlap_suppression_tb passed");
    else
      $display("box_overlap_suppression_tb failed");
    $finish;
  end
endmodule
